// ----- hdl/sts_pkg.sv -----
// ----------------------------------------------------------------------------
// sts_pkg: shared types and constants of the script token scanner
// Token kinds, field widths, keyword table and result structs.
// ----------------------------------------------------------------------------
package sts_pkg;

  localparam int SOURCE_LIMIT_DEF = 1048576;

  localparam int KIND_W  = 5;
  localparam int START_W = 20;
  localparam int LEN_W   = 21;
  localparam int LINE_W  = 21;
  localparam int COL_W   = 21;
  localparam int KWBUF_W = 48;
  localparam int KWCNT_W = 3;
  localparam int KW_NUM  = 14;

  localparam logic [START_W-1:0] START_MAX = 20'hFFFFF;
  localparam logic [LEN_W-1:0]   LEN_MAX   = 21'h100000;
  localparam logic [LINE_W-1:0]  LINE_MAX  = 21'h100000;
  localparam logic [COL_W-1:0]   COL_MAX   = 21'h100001;

  localparam logic [KIND_W-1:0] K_END     = 5'd0;
  localparam logic [KIND_W-1:0] K_IDENT   = 5'd1;
  localparam logic [KIND_W-1:0] K_INT     = 5'd2;
  localparam logic [KIND_W-1:0] K_KW0     = 5'd3;
  localparam logic [KIND_W-1:0] K_PLUS    = 5'd17;
  localparam logic [KIND_W-1:0] K_PLUS_EQ = 5'd18;
  localparam logic [KIND_W-1:0] K_EQ      = 5'd19;
  localparam logic [KIND_W-1:0] K_LBRACE  = 5'd20;
  localparam logic [KIND_W-1:0] K_RBRACE  = 5'd21;
  localparam logic [KIND_W-1:0] K_LPAREN  = 5'd22;
  localparam logic [KIND_W-1:0] K_RPAREN  = 5'd23;
  localparam logic [KIND_W-1:0] K_SEMI    = 5'd24;
  localparam logic [KIND_W-1:0] K_SLASH   = 5'd25;
  localparam logic [KIND_W-1:0] K_STAR    = 5'd26;
  localparam logic [KIND_W-1:0] K_MINUS   = 5'd27;
  localparam logic [KIND_W-1:0] K_ERROR   = 5'd28;

  // keywords packed big-endian, right aligned, in kind order
  localparam logic [KWBUF_W-1:0] KW_WORD [KW_NUM] = '{
    48'h000000766172,   // var
    48'h00636f6e7374,   // const
    48'h000000006966,   // if
    48'h0000656c6966,   // elif
    48'h0000656c7365,   // else
    48'h007768696c65,   // while
    48'h000000666f72,   // for
    48'h000066756e63,   // func
    48'h72657475726e,   // return
    48'h000054727565,   // True
    48'h0046616c7365,   // False
    48'h000000616e64,   // and
    48'h000000006f72,   // or
    48'h0000006e6f74    // not
  };

  localparam logic [KWCNT_W-1:0] KW_LEN [KW_NUM] = '{
    3'd3, 3'd5, 3'd2, 3'd4, 3'd4, 3'd5, 3'd3,
    3'd4, 3'd6, 3'd4, 3'd5, 3'd3, 3'd2, 3'd3
  };

  typedef struct packed {
    logic [KIND_W-1:0]  kind;
    logic [START_W-1:0] start_offset;
    logic [LEN_W-1:0]   token_length;
    logic [LINE_W-1:0]  line_number;
    logic [COL_W-1:0]   column_number;
    logic               last_of_run;
  } sts_token_t;

  // tokens caused by one byte: first, then second when count is two
  typedef struct packed {
    logic [1:0] count;
    sts_token_t first;
    sts_token_t second;
  } sts_emit_t;

  // kind of a finished identifier; counts above six never match
  function automatic logic [KIND_W-1:0] kw_kind(input logic [KWBUF_W-1:0] word,
                                                input logic [KWCNT_W-1:0] cnt);
    logic [KIND_W-1:0] kind;
    kind = K_IDENT;
    for (int i = 0; i < KW_NUM; i++) begin
      if (cnt == KW_LEN[i] && word == KW_WORD[i]) begin
        kind = K_KW0 + KIND_W'(i);
      end
    end
    return kind;
  endfunction

endpackage

// ----- hdl/sts_byte_if.sv -----
// ----------------------------------------------------------------------------
// sts_byte_if: source byte channel
// Valid/ready channel carrying one source byte per transaction.
// ----------------------------------------------------------------------------
interface sts_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] source_byte;

  modport source (output valid, output source_byte, input ready);
  modport sink (input valid, input source_byte, output ready);
endinterface

// ----- hdl/sts_token_if.sv -----
// ----------------------------------------------------------------------------
// sts_token_if: token channel
// Valid/ready channel carrying one token per transaction.
// ----------------------------------------------------------------------------
interface sts_token_if import sts_pkg::*; ;
  logic               valid;
  logic               ready;
  logic [KIND_W-1:0]  token_kind;
  logic [START_W-1:0] start_offset;
  logic [LEN_W-1:0]   token_length;
  logic [LINE_W-1:0]  line_number;
  logic [COL_W-1:0]   column_number;
  logic               last_of_run;

  modport source (output valid, output token_kind, output start_offset,
                  output token_length, output line_number, output column_number,
                  output last_of_run, input ready);
  modport sink (input valid, input token_kind, input start_offset,
                input token_length, input line_number, input column_number,
                input last_of_run, output ready);
endinterface

// ----- hdl/sts_lexer.sv -----
// ----------------------------------------------------------------------------
// sts_lexer: scan state and token forming
// Holds the scan mode and position counters; forms up to two tokens per byte.
// ----------------------------------------------------------------------------
module sts_lexer import sts_pkg::*; #(
  parameter int SOURCE_LIMIT = SOURCE_LIMIT_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       take,
  input  logic [7:0] source_byte,
  output sts_emit_t  result
);

  localparam int OffW = $clog2(SOURCE_LIMIT + 1);
  localparam int CmpW = (OffW > LEN_W) ? OffW : LEN_W;

  localparam logic [2:0] M_IDLE    = 3'd0;
  localparam logic [2:0] M_IDENT   = 3'd1;
  localparam logic [2:0] M_NUMBER  = 3'd2;
  localparam logic [2:0] M_PLUS    = 3'd3;
  localparam logic [2:0] M_SLASH   = 3'd4;
  localparam logic [2:0] M_COMMENT = 3'd5;

  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_EQ    = 8'h3D;
  localparam logic [7:0] CH_USCORE = 8'h5F;

  logic [2:0]         mode, mode_next;
  logic [OffW-1:0]    token_start, token_start_next;
  logic [OffW-1:0]    byte_offset, byte_offset_next;
  logic [KWBUF_W-1:0] keyword_buffer, keyword_buffer_next;
  logic [KWCNT_W-1:0] ident_count, ident_count_next;
  logic [LINE_W-1:0]  line_count, line_count_next;
  logic [COL_W-1:0]   column_count, column_count_next;

  logic [OffW-1:0]   off_adv;
  logic [LINE_W-1:0] line_adv;
  logic [COL_W-1:0]  col_adv;
  logic is_space, is_digit, is_alpha, is_id, fall;
  sts_token_t tok_a, tok_b;
  logic a_v, b_v;

  function automatic logic [START_W-1:0] clamp_start(input logic [OffW-1:0] s);
    logic [CmpW-1:0] w;
    w = CmpW'(s);
    return (w > CmpW'(START_MAX)) ? START_MAX : w[START_W-1:0];
  endfunction

  function automatic logic [LEN_W-1:0] clamp_len(input logic [OffW-1:0] s);
    logic [CmpW-1:0] w;
    w = CmpW'(s);
    return (w > CmpW'(LEN_MAX)) ? LEN_MAX : w[LEN_W-1:0];
  endfunction

  function automatic logic [KIND_W-1:0] single_kind(input logic [7:0] c);
    logic [KIND_W-1:0] k;
    unique case (c)
      8'h3D:   k = K_EQ;
      8'h7B:   k = K_LBRACE;
      8'h7D:   k = K_RBRACE;
      8'h28:   k = K_LPAREN;
      8'h29:   k = K_RPAREN;
      8'h3B:   k = K_SEMI;
      8'h2A:   k = K_STAR;
      8'h2D:   k = K_MINUS;
      default: k = K_ERROR;
    endcase
    return k;
  endfunction

  assign is_space = (source_byte == 8'h20) || (source_byte >= 8'h09 && source_byte <= 8'h0D);
  assign is_digit = (source_byte >= 8'h30) && (source_byte <= 8'h39);
  assign is_alpha = ((source_byte >= 8'h61) && (source_byte <= 8'h7A)) ||
                    ((source_byte >= 8'h41) && (source_byte <= 8'h5A));
  assign is_id    = is_alpha || is_digit || (source_byte == CH_USCORE);

  // position after consuming the current byte
  always_comb begin
    if (source_byte == CH_LF) begin
      line_adv = (line_count < LINE_MAX) ? line_count + LINE_W'(1) : line_count;
      col_adv  = COL_W'(1);
    end else begin
      line_adv = line_count;
      col_adv  = (column_count < COL_MAX) ? column_count + COL_W'(1) : column_count;
    end
    off_adv = (byte_offset < OffW'(SOURCE_LIMIT)) ? byte_offset + OffW'(1) : byte_offset;
  end

  always_comb begin
    mode_next           = mode;
    token_start_next    = token_start;
    byte_offset_next    = byte_offset;
    keyword_buffer_next = keyword_buffer;
    ident_count_next    = ident_count;
    line_count_next     = line_count;
    column_count_next   = column_count;
    fall = 1'b1;
    a_v  = 1'b0;
    b_v  = 1'b0;
    tok_a = '{kind: K_IDENT, start_offset: clamp_start(token_start),
              token_length: clamp_len(byte_offset - token_start),
              line_number: line_count, column_number: column_count, last_of_run: 1'b0};
    tok_b = '{kind: K_END, start_offset: clamp_start(byte_offset),
              token_length: '0, line_number: line_count,
              column_number: column_count, last_of_run: 1'b0};

    // finish or continue the pending token
    unique case (mode)
      M_IDENT, M_NUMBER: begin
        if ((mode == M_IDENT) ? is_id : is_digit) begin
          fall = 1'b0;
          if (mode == M_IDENT) begin
            keyword_buffer_next = {keyword_buffer[KWBUF_W-9:0], source_byte};
            ident_count_next = (ident_count < 3'd7) ? ident_count + 3'd1 : ident_count;
          end
        end else begin
          a_v = 1'b1;
          tok_a.kind = (mode == M_IDENT) ? kw_kind(keyword_buffer, ident_count) : K_INT;
        end
      end
      M_PLUS: begin
        a_v = 1'b1;
        tok_a.token_length = LEN_W'(1);
        if (source_byte == CH_EQ) begin
          fall = 1'b0;
          mode_next = M_IDLE;
          tok_a.kind = K_PLUS_EQ;
          tok_a.token_length = LEN_W'(2);
          tok_a.line_number = line_adv;
          tok_a.column_number = col_adv;
        end else begin
          tok_a.kind = K_PLUS;
        end
      end
      M_SLASH: begin
        if (source_byte == CH_SLASH) begin
          fall = 1'b0;
          mode_next = M_COMMENT;
        end else begin
          a_v = 1'b1;
          tok_a.kind = K_SLASH;
          tok_a.token_length = LEN_W'(1);
        end
      end
      M_COMMENT: begin
        if (source_byte != CH_NUL && source_byte != CH_LF) begin
          fall = 1'b0;
        end
      end
      default: ;
    endcase

    if (!fall) begin
      byte_offset_next  = off_adv;
      line_count_next   = line_adv;
      column_count_next = col_adv;
    end else begin
      mode_next = M_IDLE;
      if (source_byte == CH_NUL) begin
        // end of source: end token at current position, then back to reset
        b_v = 1'b1;
        token_start_next    = '0;
        byte_offset_next    = '0;
        keyword_buffer_next = '0;
        ident_count_next    = '0;
        line_count_next     = LINE_W'(1);
        column_count_next   = COL_W'(1);
      end else begin
        byte_offset_next  = off_adv;
        line_count_next   = line_adv;
        column_count_next = col_adv;
        if (is_space) begin
          mode_next = M_IDLE;
        end else if (is_alpha || source_byte == CH_USCORE) begin
          mode_next = M_IDENT;
          token_start_next = byte_offset;
          keyword_buffer_next = KWBUF_W'(source_byte);
          ident_count_next = 3'd1;
        end else if (is_digit) begin
          mode_next = M_NUMBER;
          token_start_next = byte_offset;
        end else if (source_byte == CH_PLUS || source_byte == CH_SLASH) begin
          mode_next = (source_byte == CH_PLUS) ? M_PLUS : M_SLASH;
          token_start_next = byte_offset;
        end else begin
          b_v = 1'b1;
          tok_b.kind = single_kind(source_byte);
          tok_b.token_length = LEN_W'(1);
          tok_b.line_number = line_adv;
          tok_b.column_number = col_adv;
        end
      end
    end

    tok_a.last_of_run = !b_v;
    tok_b.last_of_run = 1'b1;
    result.count  = {1'b0, a_v} + {1'b0, b_v};
    result.first  = a_v ? tok_a : tok_b;
    result.second = tok_b;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode           <= M_IDLE;
      token_start    <= '0;
      byte_offset    <= '0;
      keyword_buffer <= '0;
      ident_count    <= '0;
      line_count     <= LINE_W'(1);
      column_count   <= COL_W'(1);
    end else if (take) begin
      mode           <= mode_next;
      token_start    <= token_start_next;
      byte_offset    <= byte_offset_next;
      keyword_buffer <= keyword_buffer_next;
      ident_count    <= ident_count_next;
      line_count     <= line_count_next;
      column_count   <= column_count_next;
    end
  end

  // end of source returns the scanner to its reset position
  a_eos_reset: assert property (@(posedge clk) disable iff (rst)
    take && source_byte == CH_NUL |=> mode == M_IDLE && byte_offset == '0 &&
      line_count == LINE_W'(1) && column_count == COL_W'(1))
    else $error("scanner state not cleared after end of source");

  // a one-byte operator waits right behind its start
  a_op_start: assert property (@(posedge clk) disable iff (rst)
    mode == M_PLUS || mode == M_SLASH |-> byte_offset - token_start <= OffW'(1))
    else $error("operator start drifted from byte offset");

  a_ident_cnt: assert property (@(posedge clk) disable iff (rst)
    mode == M_IDENT |-> ident_count != '0)
    else $error("identifier in progress with zero byte count");

endmodule

// ----- hdl/script_token_scanner_top.sv -----
// ----------------------------------------------------------------------------
// script_token_scanner_top: streaming tokenizer for script source text
// One source byte in per transaction, tokens out with kind, offset and position.
// ----------------------------------------------------------------------------
// Usage:
//   src carries one source byte per transaction; byte 0 ends the source.
//   tok carries one token per transaction: kind, start offset, length, and
//   the line and column of the byte after the token. last_of_run marks the
//   final token caused by one input byte (a byte causes zero, one or two).
//   A token is written into the result queue when the byte that finishes it is
//   accepted. Identifiers, integers, '+' and '/' are finished by the byte
//   after them, so their token follows that byte.
//   Throughput: one byte per cycle while tokens drain at one per cycle and
//   the queue keeps room for two; a byte causing two tokens takes two output
//   transactions. The rate is set by the single output port of the four-entry
//   result queue: a byte is taken whenever the queue has room for two tokens.
//   Stall: when tok.ready stays low src.ready drops once three or more
//   tokens wait in the queue; nothing is lost or repeated.
//   Reset: rst (synchronous) empties the queue and returns the scanner to
//   line 1, column 1, offset 0. End of source does the same to the scanner
//   after its end token.
// ----------------------------------------------------------------------------
module script_token_scanner_top import sts_pkg::*; #(
  parameter int SOURCE_LIMIT = SOURCE_LIMIT_DEF
) (
  input logic        clk,
  input logic        rst,
  sts_byte_if.sink   src,
  sts_token_if.source tok
);

  localparam int Depth = 4;
  localparam int PtrW  = $clog2(Depth);
  localparam int CntW  = $clog2(Depth + 1);

  sts_emit_t  result;
  sts_token_t fifo_q [Depth];
  logic [PtrW-1:0] head, tail;
  logic [CntW-1:0] count;
  logic take, pop;
  sts_token_t head_tok;

  // room for the worst case of two tokens per byte
  assign src.ready = (count <= CntW'(Depth - 2));
  assign take = src.valid && src.ready;
  assign pop  = tok.valid && tok.ready;

  sts_lexer #(
    .SOURCE_LIMIT (SOURCE_LIMIT)
  ) u_lexer (
    .clk         (clk),
    .rst         (rst),
    .take        (take),
    .source_byte (src.source_byte),
    .result      (result)
  );

  // result queue: control state
  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      tail  <= '0;
      count <= '0;
    end else begin
      if (pop) begin
        head <= head + PtrW'(1);
      end
      if (take) begin
        tail <= tail + PtrW'(result.count);
      end
      count <= count + (take ? CntW'(result.count) : CntW'(0)) - CntW'(pop);
    end
  end

  // result queue: payload, no reset
  always_ff @(posedge clk) begin
    if (take && result.count != 2'd0) begin
      fifo_q[tail] <= result.first;
    end
    if (take && result.count == 2'd2) begin
      fifo_q[tail + PtrW'(1)] <= result.second;
    end
  end

  assign head_tok          = fifo_q[head];
  assign tok.valid         = (count != '0);
  assign tok.token_kind    = head_tok.kind;
  assign tok.start_offset  = head_tok.start_offset;
  assign tok.token_length  = head_tok.token_length;
  assign tok.line_number   = head_tok.line_number;
  assign tok.column_number = head_tok.column_number;
  assign tok.last_of_run   = head_tok.last_of_run;

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    count <= CntW'(Depth))
    else $error("result queue overflow");

  // a token that is not last of its run has its partner queued behind it
  a_run_whole: assert property (@(posedge clk) disable iff (rst)
    tok.valid && !tok.last_of_run |-> count >= CntW'(2))
    else $error("token run split in result queue");

  a_no_empty_pop: assert property (@(posedge clk) disable iff (rst)
    take && result.count == 2'd2 |=> count >= CntW'(2))
    else $error("two-token transaction not fully queued");

endmodule

// ----- bench/tb_sts_pkg.sv -----
// ----------------------------------------------------------------------------
// tb_sts_pkg: token scoreboard for the script token scanner bench
// Byte classes, keyword spellings, and a scoreboard class that tracks the
// scanner state, queues the tokens each accepted byte should produce, and
// checks every token leaving the block against the oldest queued one.
// ----------------------------------------------------------------------------
package tb_sts_pkg;
  import sts_pkg::*;

  typedef enum logic [2:0] {
    SCAN_IDLE, SCAN_WORD, SCAN_DIGITS, SCAN_PLUS, SCAN_SLASH, SCAN_COMMENT
  } scan_state_t;

  localparam int unsigned OFFSET_CAP = SOURCE_LIMIT_DEF;

  function automatic bit is_space(logic [7:0] c);
    return c == 8'h20 || (c >= 8'h09 && c <= 8'h0D);
  endfunction

  function automatic bit is_digit(logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic bit is_alpha(logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
  endfunction

  function automatic bit is_word_char(logic [7:0] c);
    return is_alpha(c) || is_digit(c) || c == "_";
  endfunction

  // spellings in kind order
  function automatic string keyword_text(int idx);
    case (idx)
      0: return "var";
      1: return "const";
      2: return "if";
      3: return "elif";
      4: return "else";
      5: return "while";
      6: return "for";
      7: return "func";
      8: return "return";
      9: return "True";
      10: return "False";
      11: return "and";
      12: return "or";
      default: return "not";
    endcase
  endfunction

  class token_scoreboard;
    sts_token_t         due_tokens[$];
    int unsigned        bad_count;
    int unsigned        token_count;
    scan_state_t        mode;
    int unsigned        tok_start;
    int unsigned        offset;
    int unsigned        line;
    int unsigned        col;
    int unsigned        word_len;
    logic [KWBUF_W-1:0] word;

    function new();
      clear();
      bad_count = 0;
      token_count = 0;
    endfunction

    function void clear();
      mode = SCAN_IDLE;
      tok_start = 0;
      offset = 0;
      word = '0;
      word_len = 0;
      line = 1;
      col = 1;
    endfunction

    function void bump(logic [7:0] c);
      if (c == 8'h0A) begin
        if (line < LINE_MAX) line++;
        col = 1;
      end else if (col < COL_MAX) begin
        col++;
      end
      if (offset < OFFSET_CAP) offset++;
    endfunction

    function void push_token(logic [KIND_W-1:0] kind, int unsigned start, int unsigned len);
      sts_token_t t;
      t.kind = kind;
      t.start_offset = (start > START_MAX) ? START_MAX : START_W'(start);
      t.token_length = (len > LEN_MAX) ? LEN_MAX : LEN_W'(len);
      t.line_number = LINE_W'(line);
      t.column_number = COL_W'(col);
      t.last_of_run = 1'b0;
      due_tokens.push_back(t);
    endfunction

    function logic [KIND_W-1:0] word_kind();
      logic [KWBUF_W-1:0] kw_bits;
      string              s;
      if (word_len > 6) return K_IDENT;
      for (int i = 0; i < KW_NUM; i++) begin
        s = keyword_text(i);
        kw_bits = '0;
        for (int j = 0; j < s.len(); j++) kw_bits = {kw_bits[KWBUF_W-9:0], s[j]};
        if (s.len() == word_len && kw_bits == word) return K_KW0 + KIND_W'(i);
      end
      return K_IDENT;
    endfunction

    function logic [KIND_W-1:0] punct_kind(logic [7:0] c);
      case (c)
        "=": return K_EQ;
        "{": return K_LBRACE;
        "}": return K_RBRACE;
        "(": return K_LPAREN;
        ")": return K_RPAREN;
        ";": return K_SEMI;
        "*": return K_STAR;
        "-": return K_MINUS;
        default: return K_ERROR;
      endcase
    endfunction

    // accepted byte: advance the scanner and queue the tokens it causes
    function void note_byte(logic [7:0] c);
      int unsigned first_new;
      int unsigned s;
      bit          taken;
      first_new = due_tokens.size();
      taken = 1'b0;
      case (mode)
        SCAN_WORD, SCAN_DIGITS: begin
          if (mode == SCAN_WORD ? is_word_char(c) : is_digit(c)) begin
            if (mode == SCAN_WORD) begin
              word = {word[KWBUF_W-9:0], c};
              if (word_len < 7) word_len++;
            end
            bump(c);
            taken = 1'b1;
          end else begin
            push_token(mode == SCAN_WORD ? word_kind() : K_INT, tok_start, offset - tok_start);
            mode = SCAN_IDLE;
          end
        end
        SCAN_PLUS: begin
          mode = SCAN_IDLE;
          if (c == "=") begin
            bump(c);
            push_token(K_PLUS_EQ, tok_start, 2);
            taken = 1'b1;
          end else begin
            push_token(K_PLUS, tok_start, 1);
          end
        end
        SCAN_SLASH: begin
          if (c == "/") begin
            mode = SCAN_COMMENT;
            bump(c);
            taken = 1'b1;
          end else begin
            mode = SCAN_IDLE;
            push_token(K_SLASH, tok_start, 1);
          end
        end
        SCAN_COMMENT: begin
          if (c != 8'h00 && c != 8'h0A) begin
            bump(c);
            taken = 1'b1;
          end else begin
            mode = SCAN_IDLE;
          end
        end
        default: mode = SCAN_IDLE;
      endcase

      if (!taken) begin
        if (c == 8'h00) begin
          push_token(K_END, offset, 0);
          clear();
        end else if (is_space(c)) begin
          bump(c);
        end else if (is_alpha(c) || c == "_") begin
          mode = SCAN_WORD;
          tok_start = offset;
          word = KWBUF_W'(c);
          word_len = 1;
          bump(c);
        end else if (is_digit(c)) begin
          mode = SCAN_DIGITS;
          tok_start = offset;
          bump(c);
        end else if (c == "+" || c == "/") begin
          mode = (c == "+") ? SCAN_PLUS : SCAN_SLASH;
          tok_start = offset;
          bump(c);
        end else begin
          s = offset;
          bump(c);
          push_token(punct_kind(c), s, 1);
        end
      end

      if (due_tokens.size() > first_new) due_tokens[due_tokens.size()-1].last_of_run = 1'b1;
    endfunction

    function void report(string field, int unsigned want, int unsigned got);
      $display("%0t: token %0d %s mismatch, expected %0d actual %0d",
               $time, token_count, field, want, got);
      bad_count++;
    endfunction

    function void check_token(sts_token_t got);
      sts_token_t want;
      token_count++;
      if (due_tokens.size() == 0) begin
        $display("%0t: unexpected token, expected none actual kind %0d start %0d",
                 $time, got.kind, got.start_offset);
        bad_count++;
        return;
      end
      want = due_tokens.pop_front();
      if (got.kind != want.kind) report("kind", want.kind, got.kind);
      if (got.start_offset != want.start_offset)
        report("start_offset", want.start_offset, got.start_offset);
      if (got.token_length != want.token_length)
        report("token_length", want.token_length, got.token_length);
      if (got.line_number != want.line_number)
        report("line_number", want.line_number, got.line_number);
      if (got.column_number != want.column_number)
        report("column_number", want.column_number, got.column_number);
      if (got.last_of_run != want.last_of_run)
        report("last_of_run", want.last_of_run, got.last_of_run);
    endfunction
  endclass

endpackage

// ----- bench/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top: bench for script_token_scanner_top
// Streams short source texts through the scanner: a directed opener for the
// corner cases, then randomly built sources made mostly of valid tokens with
// noise mixed in. Every accepted byte is fed to the scoreboard, which queues
// the tokens it should cause; every token leaving the block is checked
// field by field. Both channels idle at random, and the token side holds
// off once for a long stretch so that the block backs up into its input.
// ----------------------------------------------------------------------------
module tb_top import sts_pkg::*, tb_sts_pkg::*; ;

  localparam int ITEM_TARGET  = 950;  // source bytes in the random part
  localparam int HOLD_AFTER   = 300;  // start of the long output hold-off
  localparam int HOLD_CYCLES  = 200;
  localparam int DRAIN_CYCLES = 16;   // wait after the scoreboard has no tokens due

  logic clk = 1'b0;
  logic rst;

  sts_byte_if  src_if ();
  sts_token_if tok_if ();

  script_token_scanner_top dut (
    .clk(clk),
    .rst(rst),
    .src(src_if),
    .tok(tok_if)
  );

  token_scoreboard sb;

  logic [7:0]  text_q[$];          // bytes waiting to be sent
  int          burst_left = 0;
  int unsigned bytes_sent = 0;
  int unsigned items_sent = 0;
  int unsigned sources_sent = 0;
  bit          hold_request = 1'b0;
  bit          hold_active = 1'b0;
  bit          hold_done = 1'b0;
  logic [31:0] kinds_seen = '0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // --------------------------------------------------------------------------
  // Text building
  // --------------------------------------------------------------------------
  task automatic add_text(string s);
    for (int i = 0; i < s.len(); i++) text_q.push_back(s[i]);
  endtask

  function automatic logic [7:0] word_head();
    int unsigned r;
    r = $urandom_range(0, 52);
    if (r < 26) return 8'h61 + 8'(r);
    if (r < 52) return 8'h41 + 8'(r - 26);
    return "_";
  endfunction

  function automatic logic [7:0] word_tail();
    if ($urandom_range(0, 5) == 0) return 8'h30 + 8'($urandom_range(0, 9));
    return word_head();
  endfunction

  // mostly spaces and newlines, now and then the rarer control blanks
  function automatic logic [7:0] blank_byte();
    case ($urandom_range(0, 7))
      0, 1, 2: return 8'h20;
      3, 4: return 8'h0A;
      5: return 8'h09;
      default: return 8'($urandom_range(11, 13));
    endcase
  endfunction

  task automatic add_random_token();
    string      s;
    int         n;
    logic [7:0] b;
    case ($urandom_range(0, 13))
      0, 1: add_text(keyword_text($urandom_range(0, KW_NUM - 1)));
      2, 3: begin
        // identifiers up to nine bytes, past the six that can match a keyword
        n = $urandom_range(1, 9);
        text_q.push_back(word_head());
        for (int i = 1; i < n; i++) text_q.push_back(word_tail());
      end
      4: begin
        // near misses: keyword with a leading or trailing extra character
        s = keyword_text($urandom_range(0, KW_NUM - 1));
        if ($urandom_range(0, 1) == 0) begin
          add_text(s);
          text_q.push_back(word_tail());
        end else begin
          text_q.push_back(word_head());
          add_text(s);
        end
      end
      5, 6: begin
        n = $urandom_range(1, 7);
        for (int i = 0; i < n; i++) text_q.push_back(8'h30 + 8'($urandom_range(0, 9)));
      end
      7, 8: begin
        s = "+={}()*-;/";
        if ($urandom_range(0, 4) == 0) add_text("+=");
        else text_q.push_back(s[$urandom_range(0, s.len() - 1)]);
      end
      9: begin
        // line comment; the newline is sometimes missing so it runs on into the following text
        add_text("//");
        n = $urandom_range(0, 12);
        for (int i = 0; i < n; i++) begin
          b = 8'($urandom_range(1, 255));
          if (b == 8'h0A) b = "#";
          text_q.push_back(b);
        end
        if ($urandom_range(0, 9) != 0) text_q.push_back(8'h0A);
      end
      10: text_q.push_back(8'($urandom_range(1, 255)));
      11: text_q.push_back(8'($urandom_range(128, 255)));
      default: text_q.push_back(blank_byte());
    endcase
  endtask

  // one source: a run of tokens, sometimes none, closed by the zero byte
  task automatic add_random_source();
    int count;
    count = ($urandom_range(0, 15) == 0) ? 0 : $urandom_range(1, 24);
    repeat (count) begin
      add_random_token();
      if ($urandom_range(0, 9) < 6) text_q.push_back(blank_byte());
    end
    text_q.push_back(8'h00);
  endtask

  // --------------------------------------------------------------------------
  // Byte sender: called at a falling edge, returns at a falling edge
  // --------------------------------------------------------------------------
  task automatic send_byte(logic [7:0] b);
    src_if.valid <= 1'b1;
    src_if.source_byte <= b;
    do @(posedge clk); while (!src_if.ready);
    sb.note_byte(b);
    bytes_sent++;
    items_sent++;
    if (b == 8'h00) sources_sent++;
    if (items_sent >= HOLD_AFTER && !hold_done) hold_request = 1'b1;
    @(negedge clk);
  endtask

  // drain text_q in bursts; no gaps while the token side is held off, so the
  // scanner keeps being offered bytes until it stalls
  task automatic send_text();
    logic [7:0] b;
    while (text_q.size() > 0) begin
      if (burst_left <= 0) begin
        if (!hold_active && $urandom_range(0, 3) != 0) begin
          src_if.valid <= 1'b0;
          src_if.source_byte <= 8'($urandom_range(0, 255));
          repeat ($urandom_range(1, 6)) @(negedge clk);
        end
        burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(60, 200)
                                                 : $urandom_range(1, 24);
      end
      b = text_q.pop_front();
      send_byte(b);
      burst_left--;
    end
  endtask

  // --------------------------------------------------------------------------
  // Stimulus and end of run
  // --------------------------------------------------------------------------
  initial begin : stimulus
    sb = new();
    rst = 1'b1;
    src_if.valid = 1'b0;
    src_if.source_byte = 8'h00;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // "+=" then a plus finished by a letter; an identifier finished by '/';
    // a comment that runs into the end of source
    add_text("+=+x//c");
    text_q.push_back(8'h00);
    // lone slash right before the end, then an empty source
    add_text("/");
    text_q.push_back(8'h00);
    text_q.push_back(8'h00);
    // non-ASCII bytes, blanks, every single-byte operator but '+' and '/', a number cut by a
    // keyword, the rarer blanks, and a number flushed by the end byte
    text_q.push_back(8'h80);
    text_q.push_back(8'hFF);
    add_text("\t\n{}()*-=;9return");
    text_q.push_back(8'h0B);
    text_q.push_back(8'h0C);
    text_q.push_back(8'h0D);
    add_text(" 7");
    text_q.push_back(8'h00);
    send_text();

    items_sent = 0;
    while (items_sent < ITEM_TARGET) begin
      add_random_source();
      send_text();
    end
    src_if.valid <= 1'b0;

    while (sb.due_tokens.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("run covered %0d sources, %0d bytes and %0d tokens checked",
             sources_sent, bytes_sent, sb.token_count);
    $display("distinct token kinds seen: %0d of 29, with one %0d-cycle output hold-off",
             $countones(kinds_seen), HOLD_CYCLES);
    if (sb.bad_count == 0 && sb.due_tokens.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  // --------------------------------------------------------------------------
  // Token receiver: ready pattern in phases of random length; one long
  // hold-off once the sender has pushed enough bytes
  // --------------------------------------------------------------------------
  initial begin : token_sink
    int phase;
    int phase_left;
    phase = 0;
    phase_left = 0;
    tok_if.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_request && !hold_done) begin
        hold_active = 1'b1;
        tok_if.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_active = 1'b0;
        hold_done = 1'b1;
        hold_request = 1'b0;
      end
      if (phase_left <= 0) begin
        phase = $urandom_range(0, 3);
        phase_left = $urandom_range(16, 96);
      end
      phase_left--;
      case (phase)
        0: tok_if.ready <= 1'b1;                          // no stalls
        1: tok_if.ready <= ($urandom_range(0, 3) != 0);   // light stalls
        2: tok_if.ready <= ($urandom_range(0, 9) < 3);    // heavy stalls
        default: tok_if.ready <= ~tok_if.ready;           // alternating
      endcase
    end
  end

  // sample completed token transactions at the rising edge
  always @(posedge clk) begin : token_monitor
    sts_token_t got;
    if (!rst && tok_if.valid && tok_if.ready) begin
      got.kind = tok_if.token_kind;
      got.start_offset = tok_if.start_offset;
      got.token_length = tok_if.token_length;
      got.line_number = tok_if.line_number;
      got.column_number = tok_if.column_number;
      got.last_of_run = tok_if.last_of_run;
      kinds_seen[got.kind] = 1'b1;
      sb.check_token(got);
    end
  end

  // hard stop, far beyond the slowest legal run
  initial begin : watchdog
    #3000000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule
